### rtl/timecode_label_to_frame_count_assert.svh
// ----------------------------------------------------------------------------
// Timecode label to frame count - assertion macros
// Assertion forms used by the port checker file.
// ----------------------------------------------------------------------------
`ifndef TIMECODE_LABEL_TO_FRAME_COUNT_ASSERT_SVH
`define TIMECODE_LABEL_TO_FRAME_COUNT_ASSERT_SVH

// Property must hold at every clock edge outside reset.
`define TCLFC_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("tclfc assertion failed");

// Condition must never be seen outside reset.
`define TCLFC_NEVER(lbl, clk, rst_n, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("tclfc forbidden condition seen");

`endif

### rtl/tclfc_pkg.sv
// ----------------------------------------------------------------------------
// Timecode label to frame count - package
// Types and constants shared by the pipeline and its divider.
// ----------------------------------------------------------------------------
package tclfc_pkg;

	localparam int RATE_W  = 31;
	localparam int ADDR_W  = 3;
	localparam int COUNT_W = 25;
	localparam int FPS_W   = 8;
	localparam int SECS_W  = 17;
	localparam int MIN_W   = 12;
	localparam int DIV_STAGES = FPS_W;
	// accept to result strobe, in cycles
	localparam int LATENCY = 4 + DIV_STAGES;
	localparam logic [COUNT_W-1:0] DAY_MAX = 25'd20735999;

	localparam logic REG_RATE_NUM = 1'b0;
	localparam logic REG_RATE_DEN = 1'b1;

	typedef enum logic [1:0] {
		DROP_NONE = 2'd0,
		DROP_TWO  = 2'd1,
		DROP_FOUR = 2'd2
	} drop_t;

	typedef struct packed {
		logic              valid;
		logic              ok;
		logic [SECS_W-1:0] secs;
		logic [6:0]        frames;
		drop_t             drop;
		logic [MIN_W-1:0]  tm;
		logic [MIN_W-1:0]  tmq;
	} side_t;

endpackage

### rtl/tclfc_div.sv
// ----------------------------------------------------------------------------
// Timecode label to frame count - rate divider
// Restoring divider, one quotient bit per stage: (2*num+den)/(2*den).
// ----------------------------------------------------------------------------
module tclfc_div (
	input  logic                               clk,
	input  logic                               arst_n,
	input  tclfc_pkg::side_t                   side_in,
	input  logic [tclfc_pkg::RATE_W-1:0]       num,
	input  logic [tclfc_pkg::RATE_W-1:0]       den,
	output tclfc_pkg::side_t                   side_out,
	output logic [tclfc_pkg::FPS_W-1:0]        quo
);

	localparam int N  = tclfc_pkg::DIV_STAGES;
	localparam int RW = tclfc_pkg::RATE_W + 2;
	localparam int CW = RW + N;

	logic [RW-1:0]               rem_s  [0:N-1];
	logic [tclfc_pkg::FPS_W-1:0] quo_s  [0:N-1];
	tclfc_pkg::side_t            side_s [0:N-1];

	logic [RW-1:0] rem0;

	assign rem0 = {1'b0, num, 1'b0} + {2'b00, den};

	for (genvar i = 0; i < N; i++) begin : g_stage
		logic [RW-1:0]               r_in;
		logic [tclfc_pkg::FPS_W-1:0] q_in;
		tclfc_pkg::side_t            sd_in;
		logic [CW-1:0]               dsh;
		logic                        ge;

		if (i == 0) begin : g_first
			assign r_in  = rem0;
			assign q_in  = '0;
			assign sd_in = side_in;
		end else begin : g_next
			assign r_in  = rem_s[i-1];
			assign q_in  = quo_s[i-1];
			assign sd_in = side_s[i-1];
		end

		assign dsh = CW'({den, 1'b0}) << (N-1-i);
		assign ge  = {{(CW-RW){1'b0}}, r_in} >= dsh;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				side_s[i] <= '0;
			end else begin
				side_s[i] <= sd_in;
			end
		end

		always_ff @(posedge clk) begin
			rem_s[i] <= ge ? (r_in - dsh[RW-1:0]) : r_in;
			quo_s[i] <= q_in | (tclfc_pkg::FPS_W'(ge) << (N-1-i));
		end
	end

	assign side_out = side_s[N-1];
	assign quo      = quo_s[N-1];

endmodule

### rtl/timecode_label_to_frame_count.sv
// ----------------------------------------------------------------------------
// Timecode label to frame count
// Path: stages 1-2, divider, stages 3-4; one label accepted every cycle.
// The eight-stage rate divider sets the depth; busy is always low.
// Reset clears the pipeline valid bits and sets the rate to 30/1.
// Results appear on done for one cycle and are not held.
// ----------------------------------------------------------------------------
module timecode_label_to_frame_count (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [tclfc_pkg::ADDR_W-1:0]        paddr,
	input  logic [31:0]                         pwdata,
	output logic [31:0]                         prdata,
	output logic                                pready,
	input  logic                                start,
	output logic                                busy,
	input  logic [5:0]                          hours,
	input  logic [6:0]                          minutes,
	input  logic [6:0]                          seconds,
	input  logic [6:0]                          frames,
	input  logic                                drop_frame,
	input  logic                                label_valid,
	output logic                                done,
	output logic                                ok,
	output logic [tclfc_pkg::COUNT_W-1:0]       frame_count
);

	localparam int RW = tclfc_pkg::RATE_W;
	localparam int CW = tclfc_pkg::COUNT_W;

	logic [RW-1:0] rate_num_q;
	logic [RW-1:0] rate_den_q;

	// configuration port
	assign pready = 1'b1;
	assign busy   = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rate_num_q <= RW'(30);
			rate_den_q <= RW'(1);
		end else if (psel && penable && pwrite) begin
			unique case (paddr[2])
				tclfc_pkg::REG_RATE_NUM: rate_num_q <= pwdata[RW-1:0];
				tclfc_pkg::REG_RATE_DEN: rate_den_q <= pwdata[RW-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			tclfc_pkg::REG_RATE_NUM: prdata = {1'b0, rate_num_q};
			tclfc_pkg::REG_RATE_DEN: prdata = {1'b0, rate_den_q};
			default:                 prdata = '0;
		endcase
	end

	// stage 1: field and rate checks
	logic [47:0] d12, d240, n1001, d30k, d60k;
	logic        rng_ok, r30, r60, base_ok, tenth, skip_ok, ok_c;
	tclfc_pkg::drop_t drop_c;

	assign d12   = 48'(rate_den_q) * 48'd12;
	assign d240  = 48'(rate_den_q) * 48'd240;
	assign n1001 = 48'(rate_num_q) * 48'd1001;
	assign d30k  = 48'(rate_den_q) * 48'd30000;
	assign d60k  = 48'(rate_den_q) * 48'd60000;

	assign rng_ok = (rate_num_q != '0) && (rate_den_q != '0)
		&& (48'(rate_num_q) >= d12) && (48'(rate_num_q) <= d240);
	assign r30 = (n1001 == d30k);
	assign r60 = (n1001 == d60k);
	assign base_ok = label_valid && (hours < 6'd24) && (minutes < 7'd60)
		&& (seconds < 7'd60) && rng_ok;
	assign tenth = (minutes == 7'd0) || (minutes == 7'd10) || (minutes == 7'd20)
		|| (minutes == 7'd30) || (minutes == 7'd40) || (minutes == 7'd50);
	assign skip_ok = (seconds != 7'd0) || tenth
		|| (frames >= (r60 ? 7'd4 : 7'd2));
	assign drop_c = !drop_frame ? tclfc_pkg::DROP_NONE
		: (r60 ? tclfc_pkg::DROP_FOUR : tclfc_pkg::DROP_TWO);
	assign ok_c = base_ok && (!drop_frame || ((r30 || r60) && skip_ok));

	logic                           v_s1, ok_s1;
	logic [tclfc_pkg::MIN_W-1:0]    tm_s1;
	logic [6:0]                     sec_s1, frm_s1;
	tclfc_pkg::drop_t               drop_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		ok_s1   <= ok_c;
		tm_s1   <= 12'(hours) * 12'd60 + 12'(minutes);
		sec_s1  <= seconds;
		frm_s1  <= frames;
		drop_s1 <= drop_c;
	end

	// stage 2: seconds of day and tenth-minute count
	tclfc_pkg::side_t side_s2;
	logic [30:0]      tm_mul;

	assign tm_mul = 31'(tm_s1) * 31'd52429;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_s2 <= '0;
		end else begin
			side_s2.valid  <= v_s1;
			side_s2.ok     <= ok_s1;
			side_s2.secs   <= tclfc_pkg::SECS_W'(18'(tm_s1) * 18'd60 + 18'(sec_s1));
			side_s2.frames <= frm_s1;
			side_s2.drop   <= drop_s1;
			side_s2.tm     <= tm_s1;
			side_s2.tmq    <= tm_mul[tclfc_pkg::MIN_W+18:19];
		end
	end

	// rate divider
	tclfc_pkg::side_t            side_dv;
	logic [tclfc_pkg::FPS_W-1:0] fps_dv;

	tclfc_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.side_in  (side_s2),
		.num      (rate_num_q),
		.den      (rate_den_q),
		.side_out (side_dv),
		.quo      (fps_dv)
	);

	// stage 3: raw count and drop amount
	logic                        v_s3, ok_s3;
	logic [CW-1:0]               frame_s3;
	logic [tclfc_pkg::MIN_W:0]   drop_s3;
	logic [tclfc_pkg::MIN_W-1:0] nt;
	logic [tclfc_pkg::MIN_W:0]   drop_c3;

	assign nt = side_dv.tm - side_dv.tmq;

	always_comb begin
		case (side_dv.drop)
			tclfc_pkg::DROP_TWO:  drop_c3 = {nt, 1'b0};
			tclfc_pkg::DROP_FOUR: drop_c3 = {nt[tclfc_pkg::MIN_W-2:0], 2'b00};
			default:              drop_c3 = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else begin
			v_s3 <= side_dv.valid;
		end
	end

	always_ff @(posedge clk) begin
		ok_s3    <= side_dv.ok && (8'(side_dv.frames) < fps_dv);
		frame_s3 <= CW'(side_dv.secs) * CW'(fps_dv) + CW'(side_dv.frames);
		drop_s3  <= drop_c3;
	end

	// stage 4: output register
	logic          done_s4, ok_s4;
	logic [CW-1:0] count_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_s4 <= 1'b0;
		end else begin
			done_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		ok_s4    <= ok_s3;
		count_s4 <= ok_s3 ? (frame_s3 - CW'(drop_s3)) : '0;
	end

	assign done        = done_s4;
	assign ok          = ok_s4;
	assign frame_count = count_s4;

endmodule

### rtl/tclfc_checker.sv
// ----------------------------------------------------------------------------
// Timecode label to frame count - port checker
// Watches the top level ports for result timing and result values.
// ----------------------------------------------------------------------------
`include "timecode_label_to_frame_count_assert.svh"

module tclfc_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          start,
	input logic                          busy,
	input logic                          done,
	input logic                          ok,
	input logic [tclfc_pkg::COUNT_W-1:0] frame_count
);

	`TCLFC_ASSERT(a_beat_out, clk, arst_n, (start && !busy) |-> ##(tclfc_pkg::LATENCY) done)
	`TCLFC_ASSERT(a_no_extra, clk, arst_n, done |-> $past(start && !busy, tclfc_pkg::LATENCY))
	`TCLFC_NEVER(a_zero_bad, clk, arst_n, done && !ok && (frame_count != '0))
	`TCLFC_NEVER(a_in_day, clk, arst_n, done && ok && (frame_count > tclfc_pkg::DAY_MAX))

endmodule

bind timecode_label_to_frame_count tclfc_checker u_tclfc_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.start       (start),
	.busy        (busy),
	.done        (done),
	.ok          (ok),
	.frame_count (frame_count)
);

### tb/sv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Timecode label to frame count - testbench
// Walks a table of directed labels, then random labels under a series of
// frame rates written over APB. Each result is compared with a value typed in
// the table or with the frame index worked out from the label and current rate.
// ----------------------------------------------------------------------------
module tb;
	import tclfc_pkg::*;

	typedef struct {
		logic [5:0] hours;
		logic [6:0] minutes;
		logic [6:0] seconds;
		logic [6:0] frames;
		logic       drop_frame;
		logic       label_valid;
	} label_t;

	typedef struct {
		logic               ok;
		logic [COUNT_W-1:0] count;
	} count_t;

	typedef struct {
		logic [30:0]        num;
		logic [30:0]        den;
		label_t             lbl;
		bit                 known;
		logic               ok;
		logic [COUNT_W-1:0] count;
	} row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [ADDR_W-1:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;
	logic start = 1'b0;
	logic busy;
	logic [5:0] hours = '0;
	logic [6:0] minutes = '0, seconds = '0, frames = '0;
	logic drop_frame = 1'b0, label_valid = 1'b0;
	logic done, ok;
	logic [COUNT_W-1:0] frame_count;

	logic [30:0] cur_num = 31'd30;
	logic [30:0] cur_den = 31'd1;
	count_t pending_counts[$];
	int errors = 0;
	int cycles = 0;
	int idle_pct = 0;

	timecode_label_to_frame_count u_dut (.*);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 400000) begin
			$display("status: fail");
			$finish;
		end
	end

	function automatic count_t frame_index(label_t l, logic [30:0] num, logic [30:0] den);
		longint unsigned n, d, fps, dpm, tm, fr;
		count_t r;
		n = num;
		d = den;
		r.ok = 1'b0;
		r.count = '0;
		dpm = 0;
		if (!l.label_valid || l.hours >= 24 || l.minutes >= 60 || l.seconds >= 60) return r;
		if (n == 0 || d == 0) return r;
		if (n < 12 * d || n > 240 * d) return r;
		fps = (2 * n + d) / (2 * d);
		if (fps == 0 || l.frames >= fps) return r;
		if (l.drop_frame) begin
			if (n * 1001 == d * 60000) dpm = 4;
			else if (n * 1001 == d * 30000) dpm = 2;
			else return r;
			if (l.seconds == 0 && l.minutes % 10 != 0 && l.frames < dpm) return r;
		end
		tm = l.hours * 60 + l.minutes;
		fr = (tm * 60 + l.seconds) * fps + l.frames;
		if (dpm != 0 && (fps == 30 || fps == 60)) fr = fr - dpm * (tm - tm / 10);
		fr = fr % (86400 * fps);
		r.ok = 1'b1;
		r.count = fr[COUNT_W-1:0];
		return r;
	endfunction

	always @(posedge clk) begin
		count_t e;
		if (arst_n && done) begin
			if (pending_counts.size() == 0) begin
				$error("result with no label outstanding: ok=%0d frame_count=%0d",
					ok, frame_count);
				errors++;
			end else begin
				e = pending_counts.pop_front();
				if (ok !== e.ok) begin
					$error("ok: expected %0d, got %0d", e.ok, ok);
					errors++;
				end
				if (frame_count !== e.count) begin
					$error("frame_count: expected %0d, got %0d", e.count, frame_count);
					errors++;
				end
			end
		end
	end

	task automatic drain();
		while (pending_counts.size() != 0) @(posedge clk);
		repeat (LATENCY + 2) @(posedge clk);
	endtask

	task automatic write_rate(logic sel, logic [30:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= ADDR_W'({sel, 2'b00});
		pwdata <= {1'b0, value};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (sel == REG_RATE_NUM) cur_num = value;
		else cur_den = value;
	endtask

	task automatic set_rate(logic [30:0] num, logic [30:0] den);
		if (num == cur_num && den == cur_den) return;
		start <= 1'b0;
		@(posedge clk);
		drain();
		write_rate(REG_RATE_NUM, num);
		write_rate(REG_RATE_DEN, den);
	endtask

	// hold start high until the beat is taken, then maybe idle
	task automatic send(label_t l, bit known, count_t typed);
		start <= 1'b1;
		hours <= l.hours;
		minutes <= l.minutes;
		seconds <= l.seconds;
		frames <= l.frames;
		drop_frame <= l.drop_frame;
		label_valid <= l.label_valid;
		@(posedge clk);
		while (busy) @(posedge clk);
		pending_counts.push_back(known ? typed : frame_index(l, cur_num, cur_den));
		if ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
	endtask

	function automatic label_t rand_label(logic [30:0] num, logic [30:0] den);
		label_t l;
		int fps;
		bit dropping;
		fps = (den == 0) ? 30 : int'((64'(num) * 2 + den) / (64'(den) * 2));
		if (fps > 127 || fps < 1) fps = 127;
		dropping = (64'(num) * 1001 == 64'(den) * 30000) || (64'(num) * 1001 == 64'(den) * 60000);
		if ($urandom_range(9) == 0) begin
			l.hours = 6'($urandom);
			l.minutes = 7'($urandom);
			l.seconds = 7'($urandom);
			l.frames = 7'($urandom);
			l.drop_frame = 1'($urandom);
			l.label_valid = 1'($urandom);
		end else begin
			l.hours = 6'($urandom_range(23));
			l.minutes = 7'($urandom_range(59));
			l.seconds = 7'(($urandom_range(3) == 0) ? 0 : $urandom_range(59));
			l.frames = 7'(($urandom_range(3) == 0) ? $urandom_range(5)
				: $urandom_range(fps - 1));
			l.drop_frame = dropping ? ($urandom_range(4) != 0) : ($urandom_range(19) == 0);
			l.label_valid = ($urandom_range(29) != 0);
		end
		return l;
	endfunction

	row_t directed[$];
	logic [30:0] rate_list[$][2];

	task automatic add(logic [30:0] n, logic [30:0] d, label_t l, bit k,
		logic o = 1'b0, logic [COUNT_W-1:0] c = '0);
		directed.push_back('{n, d, l, k, o, c});
	endtask

	initial begin
		count_t typed;
		label_t l;
		logic [30:0] rn, rd;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		add(30, 1, '{0, 0, 0, 0, 0, 1}, 1, 1, 0);
		add(30, 1, '{23, 59, 59, 29, 0, 1}, 1, 1, 2591999);
		add(30, 1, '{12, 34, 56, 7, 0, 1}, 0);
		add(30, 1, '{24, 0, 0, 0, 0, 1}, 1);
		add(30, 1, '{0, 60, 0, 0, 0, 1}, 1);
		add(30, 1, '{0, 0, 60, 0, 0, 1}, 1);
		add(30, 1, '{0, 0, 0, 30, 0, 1}, 1);
		add(30, 1, '{1, 2, 3, 4, 0, 0}, 1);
		add(30, 1, '{0, 1, 0, 5, 1, 1}, 1);
		add(30, 1, '{63, 127, 127, 127, 1, 1}, 1);
		add(30000, 1001, '{0, 1, 0, 0, 1, 1}, 1);
		add(30000, 1001, '{0, 1, 0, 1, 1, 1}, 1);
		add(30000, 1001, '{0, 1, 0, 2, 1, 1}, 0);
		add(30000, 1001, '{0, 10, 0, 0, 1, 1}, 0);
		add(30000, 1001, '{23, 59, 59, 29, 1, 1}, 0);
		add(60000, 1001, '{0, 1, 0, 3, 1, 1}, 1);
		add(60000, 1001, '{0, 1, 0, 4, 1, 1}, 0);
		add(60000, 1001, '{23, 59, 59, 59, 1, 1}, 0);
		add(12, 1, '{23, 59, 59, 11, 0, 1}, 0);
		add(240, 1, '{23, 59, 59, 127, 0, 1}, 0);
		add(0, 1, '{0, 0, 0, 0, 0, 1}, 1);
		add(30, 0, '{0, 0, 0, 0, 0, 1}, 1);
		add(2147483647, 1, '{0, 0, 0, 0, 0, 1}, 1);
		add(2147483647, 2147483647, '{0, 0, 0, 0, 0, 1}, 1);
		add(1, 1, '{0, 0, 0, 0, 0, 1}, 1);

		foreach (directed[i]) begin
			set_rate(directed[i].num, directed[i].den);
			typed.ok = directed[i].ok;
			typed.count = directed[i].count;
			send(directed[i].lbl, directed[i].known, typed);
		end

		rate_list = '{'{30, 1}, '{30000, 1001}, '{60000, 1001}, '{25, 1}, '{24000, 1001},
			'{12, 1}, '{240, 1}, '{120000, 1001}, '{50, 1}, '{0, 0}, '{0, 0},
			'{2147483647, 2147483647}, '{30000, 1001}, '{60000, 1001}};
		foreach (rate_list[p]) begin
			rn = rate_list[p][0];
			rd = rate_list[p][1];
			if (rn == 0) begin
				rd = 31'($urandom_range(1, 1000));
				rn = 31'(rd * $urandom_range(12, 240) + $urandom_range(rd - 1));
			end
			set_rate(rn, rd);
			case (p % 3)
				0: idle_pct = 0;
				1: idle_pct = 83;
				default: idle_pct = 7;
			endcase
			for (int k = 0; k < 86; k++) begin
				if (k == 40 && p == 4) begin
					start <= 1'b0;
					@(posedge clk);
					while (pending_counts.size() != 0) @(posedge clk);
				end
				l = rand_label(cur_num, cur_den);
				send(l, 0, typed);
			end
		end

		start <= 1'b0;
		@(posedge clk);
		drain();
		if (errors == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule

### timecode_label_to_frame_count.f
+incdir+rtl
rtl/tclfc_pkg.sv
rtl/tclfc_div.sv
rtl/timecode_label_to_frame_count.sv
rtl/tclfc_checker.sv
tb/sv/tb.sv
